// ----- rtl/smm_pkg.sv -----
// Shared constants and types for the sample-set median and mode core.
package smm_pkg;

	localparam int MAX_SAMPLES = 256;
	localparam int SAMPLE_BITS = 16;
	localparam int MED_W       = SAMPLE_BITS + 1;
	localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
	localparam int IDX_W       = $clog2(MAX_SAMPLES);
	localparam int ADDR_W      = IDX_W + 1;
	localparam int MEM_DEPTH   = 2 * MAX_SAMPLES;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_PRIME = 7'b0000010,
		ST_MERGE = 7'b0000100,
		ST_MED1  = 7'b0001000,
		ST_MED2  = 7'b0010000,
		ST_SCAN  = 7'b0100000,
		ST_FIN   = 7'b1000000
	} state_t;

endpackage

// ----- rtl/sample_set_median_and_mode_core.sv -----
// Top level: sample store, merge sorter, median pick and mode scan.
//
// Samples are written into a store one per cycle while in_ready is high. The
// transaction marked last closes the set: the kept samples are then sorted by a
// bottom-up merge that moves one element per cycle through a single compare
// unit and a ping-pong store with two read ports and one write port. For a set
// of n samples this takes ceil(log2 n) passes, each opened by a prime step, then
// the median pick and the mode scan; in_ready stays low throughout. A finished
// result waits in the output register, so the next set can load while it is
// still pending.
module sample_set_median_and_mode_core
	import smm_pkg::*;
(
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                          last,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [MED_W-1:0]       median_twice,
	output logic signed [SAMPLE_BITS-1:0] mode_value,
	output logic                          mode_valid,
	output logic [CNT_W-1:0]              mode_count,
	output logic [CNT_W-1:0]              sample_count,
	output logic                          overflowed
);

	state_t state_q;

	logic signed [SAMPLE_BITS-1:0] mem [MEM_DEPTH];
	logic signed [SAMPLE_BITS-1:0] rd_a_q, rd_b_q;

	logic [CNT_W-1:0] fill_q;
	logic             ovf_q;
	logic             src_q;
	logic [CNT_W-1:0] w_q, i_q, j_q, ie_q, je_q, k_q;
	logic [CNT_W-1:0] scan_idx_q, idx_s1;
	logic             val_s1;
	logic signed [SAMPLE_BITS-1:0] prev_q, best_val_q;
	logic [CNT_W-1:0] run_q, best_run_q;
	logic signed [MED_W-1:0] med_q;
	logic             out_valid_q;

	logic             accept, full;
	logic [CNT_W-1:0] n_new;
	logic             i_done, j_done, take_a;
	logic [CNT_W-1:0] k_inc;
	logic             run_end, pass_end;
	logic [CNT_W:0]   lo_w, lo_2w, w_dbl, w_quad;
	logic [CNT_W-1:0] i_nx, j_nx, ie_nx, je_nx;
	logic [CNT_W-1:0] a_idx, b_idx, med_hi, med_lo;
	logic             we;
	logic [ADDR_W-1:0] wa;
	logic signed [SAMPLE_BITS-1:0] wd;
	logic [CNT_W-1:0] run_nx;
	logic             out_load;

	function automatic logic [CNT_W-1:0] cap_n(input logic [CNT_W:0] a,
		input logic [CNT_W-1:0] n);
		return (a < {1'b0, n}) ? a[CNT_W-1:0] : n;
	endfunction

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign full     = (fill_q == CNT_W'(MAX_SAMPLES));
	assign n_new    = full ? fill_q : fill_q + CNT_W'(1);
	assign out_valid = out_valid_q;
	assign out_load  = (state_q == ST_FIN) && (!out_valid_q || out_ready);

	// Merge step: pick the smaller head, or whichever run is not exhausted.
	assign i_done = (i_q == ie_q);
	assign j_done = (j_q == je_q);
	always_comb begin
		if (j_done) begin
			take_a = 1'b1;
		end else if (i_done) begin
			take_a = 1'b0;
		end else begin
			take_a = (rd_a_q <= rd_b_q);
		end
	end

	assign k_inc    = k_q + CNT_W'(1);
	assign run_end  = (k_inc == je_q);
	assign pass_end = run_end && (je_q == fill_q);
	assign lo_w     = {1'b0, je_q} + {1'b0, w_q};
	assign lo_2w    = {1'b0, je_q} + {w_q, 1'b0};
	assign w_dbl    = {w_q, 1'b0};
	assign w_quad   = {w_q[CNT_W-2:0], 2'b00};

	always_comb begin
		if (run_end && !pass_end) begin
			i_nx  = je_q;
			ie_nx = cap_n(lo_w, fill_q);
			j_nx  = cap_n(lo_w, fill_q);
			je_nx = cap_n(lo_2w, fill_q);
		end else begin
			i_nx  = i_q + CNT_W'(take_a);
			j_nx  = j_q + CNT_W'(!take_a);
			ie_nx = ie_q;
			je_nx = je_q;
		end
	end

	assign med_hi = fill_q >> 1;
	assign med_lo = med_hi - CNT_W'(1);

	// Read addresses: during a merge the next heads are fetched so that one
	// element leaves per cycle.
	always_comb begin
		case (state_q)
			ST_PRIME: begin
				a_idx = i_q;
				b_idx = j_q;
			end
			ST_MERGE: begin
				a_idx = i_nx;
				b_idx = j_nx;
			end
			ST_MED1: begin
				a_idx = med_hi;
				b_idx = med_lo;
			end
			ST_SCAN: begin
				a_idx = scan_idx_q;
				b_idx = scan_idx_q;
			end
			default: begin
				a_idx = '0;
				b_idx = '0;
			end
		endcase
	end

	always_comb begin
		if (state_q == ST_MERGE) begin
			we = 1'b1;
			wa = {~src_q, k_q[IDX_W-1:0]};
			wd = take_a ? rd_a_q : rd_b_q;
		end else begin
			we = accept && !full;
			wa = {1'b0, fill_q[IDX_W-1:0]};
			wd = sample;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd_a_q <= mem[{src_q, a_idx[IDX_W-1:0]}];
		rd_b_q <= mem[{src_q, b_idx[IDX_W-1:0]}];
	end

	assign run_nx = (rd_a_q == prev_q) ? run_q + CNT_W'(1) : CNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			ovf_q       <= 1'b0;
			src_q       <= 1'b0;
			w_q         <= '0;
			i_q         <= '0;
			j_q         <= '0;
			ie_q        <= '0;
			je_q        <= '0;
			k_q         <= '0;
			scan_idx_q  <= '0;
			idx_s1      <= '0;
			val_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (full) begin
							ovf_q <= 1'b1;
						end else begin
							fill_q <= fill_q + CNT_W'(1);
						end
						if (last) begin
							src_q <= 1'b0;
							w_q   <= CNT_W'(1);
							i_q   <= '0;
							k_q   <= '0;
							ie_q  <= CNT_W'(1);
							j_q   <= CNT_W'(1);
							je_q  <= CNT_W'(2);
							state_q <= (n_new == CNT_W'(1)) ? ST_MED1 : ST_PRIME;
						end
					end
				end
				ST_PRIME: begin
					state_q <= ST_MERGE;
				end
				ST_MERGE: begin
					if (pass_end) begin
						w_q   <= w_dbl[CNT_W-1:0];
						src_q <= ~src_q;
						i_q   <= '0;
						k_q   <= '0;
						ie_q  <= cap_n(w_dbl, fill_q);
						j_q   <= cap_n(w_dbl, fill_q);
						je_q  <= cap_n(w_quad, fill_q);
						state_q <= (w_dbl >= {1'b0, fill_q}) ? ST_MED1 : ST_PRIME;
					end else begin
						k_q  <= k_inc;
						i_q  <= i_nx;
						j_q  <= j_nx;
						ie_q <= ie_nx;
						je_q <= je_nx;
					end
				end
				ST_MED1: begin
					state_q <= ST_MED2;
				end
				ST_MED2: begin
					scan_idx_q <= '0;
					val_s1     <= 1'b0;
					state_q    <= ST_SCAN;
				end
				ST_SCAN: begin
					if (scan_idx_q < fill_q) begin
						scan_idx_q <= scan_idx_q + CNT_W'(1);
						val_s1     <= 1'b1;
					end else begin
						val_s1 <= 1'b0;
					end
					idx_s1 <= scan_idx_q;
					if (val_s1 && (idx_s1 == fill_q - CNT_W'(1))) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_load) begin
						out_valid_q <= 1'b1;
						fill_q      <= '0;
						ovf_q       <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers of the median and mode, and the output registers; they need no reset.
	always_ff @(posedge clk) begin
		if (state_q == ST_MED2) begin
			if (fill_q[0]) begin
				med_q <= {rd_a_q, 1'b0};
			end else begin
				med_q <= {rd_a_q[SAMPLE_BITS-1], rd_a_q}
					+ {rd_b_q[SAMPLE_BITS-1], rd_b_q};
			end
		end
		if (state_q == ST_SCAN && val_s1) begin
			prev_q <= rd_a_q;
			if (idx_s1 == '0) begin
				run_q      <= CNT_W'(1);
				best_run_q <= CNT_W'(1);
				best_val_q <= rd_a_q;
			end else begin
				run_q <= run_nx;
				if (run_nx > best_run_q) begin
					best_run_q <= run_nx;
					best_val_q <= rd_a_q;
				end
			end
		end
		if (out_load) begin
			median_twice <= med_q;
			mode_value   <= best_val_q;
			mode_valid   <= (best_run_q > CNT_W'(1));
			mode_count   <= best_run_q;
			sample_count <= fill_q;
			overflowed   <= ovf_q;
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(MAX_SAMPLES))
		else $error("fill count beyond capacity");

	a_merge_heads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MERGE) |-> !(i_done && j_done))
		else $error("merge step with both runs exhausted");

	a_merge_balance: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MERGE) |->
		(({1'b0, k_q} + {1'b0, ie_q}) == ({1'b0, i_q} + {1'b0, j_q})))
		else $error("merge output index out of step with run heads");

	a_mode_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (mode_count <= sample_count && mode_count != '0))
		else $error("mode count outside the kept set");

	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && last) |=> !in_ready)
		else $error("ready again directly after the closing transaction");

endmodule
